// ===== hw/rtl/mmq_pkg.sv =====
// Package for the multicast message queue: request and result structs,
// request and status codes, sequencer states. No dependencies.
package mmq_pkg;

  typedef enum logic [2:0] {
    REQ_SUBSCRIBE   = 3'd0,
    REQ_UNSUBSCRIBE = 3'd1,
    REQ_PUBLISH     = 3'd2,
    REQ_FETCH       = 3'd3,
    REQ_REMOVE      = 3'd4,
    REQ_SET_CAP     = 3'd5,
    REQ_RSVD_6      = 3'd6,
    REQ_RSVD_7      = 3'd7
  } req_code_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ALREADY    = 3'd1;
  localparam logic [2:0] ST_NOT_SUB    = 3'd2;
  localparam logic [2:0] ST_NO_SUBS    = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_EMPTY      = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd6;
  localparam logic [2:0] ST_TABLE_FULL = 3'd7;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  subscriber_id;
    logic [31:0] payload;
    logic [4:0]  new_capacity;
  } mmq_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] message_out;
    logic [4:0]  unread_count;
  } mmq_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH_CHK,
    S_SRCH_CMP,
    S_WALK_RD,
    S_WALK_WR,
    S_DONE
  } mmq_state_t;

endpackage

// ===== hw/rtl/mmq_queue_ram.sv =====
// Message store: one synchronous RAM holding word and pending-reader count.
// Depends on nothing but its parameters.
module mmq_queue_ram #(
  parameter int DEPTH = 16,
  parameter int DW    = 32,
  parameter int CW    = 4,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wword,
  input  logic [CW-1:0] wcnt,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rword,
  output logic [CW-1:0] rcnt
);
  logic [DW+CW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {wword, wcnt};
    {rword, rcnt} <= mem[raddr];
  end
endmodule

// ===== hw/rtl/multicast_message_queue_top.sv =====
// Top level of the multicast message queue: request sequencer, subscriber
// table and message RAM. Depends on mmq_pkg and mmq_queue_ram.
//
//  channel | ports                      | handshake
//  --------+----------------------------+-------------------------------
//  request | in_data (mmq_in_t)         | start & !busy
//  result  | out_data (mmq_out_t)       | out_valid, one cycle, no stall
//
// Every request is busy through the decode and done states; the result strobe
// follows in the next cycle, and a new request can be accepted at the edge that
// ends the strobe cycle. Fetch adds the S_FETCH_CHK state for the RAM read; a
// freed entry is then closed up by copying down each entry behind it.
// Unsubscribe walks from the leaver's first unread entry to the tail. Remove
// compares one entry per cycle, then closes the gap behind the match. A set
// capacity that drops messages copies the kept ones. The walks go through the
// single RAM read/write port pair, a read state and a write state per entry;
// every read is issued after the previous write has landed.
// Reset (synchronous) clears the subscriber valid bits and length and sets the
// capacity to CAPACITY; RAM content is unused until written. The receiver cannot
// stall results.
module multicast_message_queue_top #(
  parameter int CAPACITY        = 16,
  parameter int MAX_SUBSCRIBERS = 8,
  parameter int DATA_BITS       = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mmq_pkg::mmq_in_t  in_data,
  output logic              out_valid,
  output mmq_pkg::mmq_out_t out_data
);
  import mmq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int SW = (MAX_SUBSCRIBERS > 1) ? $clog2(MAX_SUBSCRIBERS) : 1;
  localparam int TW = $clog2(MAX_SUBSCRIBERS + 1);
  localparam int CW = TW;

  mmq_state_t state_r, state_nxt;
  mmq_in_t    req_r;
  logic [LW-1:0] len_r, len_nxt, cap_r, cap_nxt;
  logic [MAX_SUBSCRIBERS-1:0] sv_r, sv_nxt;
  logic [7:0]    sid_r [MAX_SUBSCRIBERS];
  logic [LW-1:0] sun_r [MAX_SUBSCRIBERS];
  logic [LW-1:0] sun_nxt [MAX_SUBSCRIBERS];
  logic [7:0]    sid_wr;
  logic [SW-1:0] sid_wa;
  logic          sid_we;
  logic [TW-1:0] tot_r, tot_nxt;
  logic [LW-1:0] pos_r, pos_nxt;    // fetch/search position, then write index
  logic [LW-1:0] rd_r, rd_nxt;      // source index during compaction
  logic          filt_r, filt_nxt;  // walk drops one reader per entry
  logic [SW-1:0] slot_r, slot_nxt;
  logic          hit_r, hit_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [31:0]   msg_r, msg_nxt;
  mmq_out_t      out_r, out_nxt;
  logic          ov_r, ov_nxt;

  // RAM port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DATA_BITS-1:0] wword, rword;
  logic [CW-1:0] wcnt, rcnt;

  mmq_queue_ram #(.DEPTH(CAPACITY), .DW(DATA_BITS), .CW(CW), .AW(AW)) u_ram (
    .clk, .we, .waddr, .wword, .wcnt, .raddr, .rword, .rcnt
  );

  // Subscriber lookup over the small table (independent compares).
  logic          found;
  logic [SW-1:0] found_slot;
  logic          has_free;
  logic [SW-1:0] free_slot;
  always_comb begin
    found = 1'b0; found_slot = '0; has_free = 1'b0; free_slot = '0;
    for (int k = MAX_SUBSCRIBERS - 1; k >= 0; k--) begin
      if (sv_r[k] && sid_r[k] == req_r.subscriber_id) begin
        found = 1'b1; found_slot = SW'(k);
      end
      if (!sv_r[k]) begin
        has_free = 1'b1; free_slot = SW'(k);
      end
    end
  end

  logic [LW-1:0] my_un;
  logic [LW-1:0] first_un;
  logic [LW-1:0] ncap;
  logic [DATA_BITS-1:0] req_word;
  logic [LW-1:0] pos_inc, rd_inc;
  logic          keep;
  assign my_un    = sun_r[found_slot];
  assign first_un = (my_un > len_r) ? '0 : len_r - my_un;
  assign ncap     = (32'(req_r.new_capacity) > CAPACITY) ? LW'(CAPACITY)
                    : LW'(req_r.new_capacity);
  assign req_word = DATA_BITS'(req_r.payload);
  assign pos_inc  = pos_r + 1'b1;
  assign rd_inc   = rd_r + 1'b1;
  // Hold an entry through the walk unless its last reader just left.
  assign keep     = !filt_r || rcnt > CW'(1);

  always_comb begin
    state_nxt = state_r;
    len_nxt = len_r; cap_nxt = cap_r; sv_nxt = sv_r; tot_nxt = tot_r;
    pos_nxt = pos_r; rd_nxt = rd_r; filt_nxt = filt_r;
    slot_nxt = slot_r; hit_nxt = hit_r;
    st_nxt = st_r; msg_nxt = msg_r;
    for (int k = 0; k < MAX_SUBSCRIBERS; k++) sun_nxt[k] = sun_r[k];
    sid_we = 1'b0; sid_wa = '0; sid_wr = req_r.subscriber_id;
    we = 1'b0; waddr = AW'(pos_r); wword = rword; wcnt = rcnt;
    raddr = AW'(rd_r);
    ov_nxt = 1'b0; out_nxt = out_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        st_nxt = ST_OK; msg_nxt = '0; slot_nxt = found_slot; hit_nxt = found;
        filt_nxt = 1'b0;
        state_nxt = S_DONE;
        case (req_r.req_type)
          REQ_SUBSCRIBE: begin
            if (found) st_nxt = ST_ALREADY;
            else if (!has_free) st_nxt = ST_TABLE_FULL;
            else begin
              sv_nxt[free_slot] = 1'b1; sid_we = 1'b1; sid_wa = free_slot;
              sun_nxt[free_slot] = '0; tot_nxt = tot_r + 1'b1;
              slot_nxt = free_slot; hit_nxt = 1'b1;
            end
          end
          REQ_UNSUBSCRIBE: begin
            if (!found) st_nxt = ST_NOT_SUB;
            else begin
              // drop the slot now, then walk its unread tail
              sv_nxt[found_slot] = 1'b0; sun_nxt[found_slot] = '0; hit_nxt = 1'b0;
              if (tot_r != '0) tot_nxt = tot_r - 1'b1;
              pos_nxt = first_un; rd_nxt = first_un; filt_nxt = 1'b1;
              if (first_un < len_r) state_nxt = S_WALK_RD;
            end
          end
          REQ_PUBLISH: begin
            if (tot_r == '0) st_nxt = ST_NO_SUBS;
            else if (len_r >= cap_r || len_r >= LW'(CAPACITY)) st_nxt = ST_FULL;
            else begin
              we = 1'b1; waddr = AW'(len_r); wword = req_word; wcnt = CW'(tot_r);
              len_nxt = len_r + 1'b1;
              for (int k = 0; k < MAX_SUBSCRIBERS; k++)
                if (sv_r[k]) sun_nxt[k] = sun_r[k] + 1'b1;
            end
          end
          REQ_FETCH: begin
            if (!found) st_nxt = ST_NOT_SUB;
            else if (my_un == '0 || len_r == '0) st_nxt = ST_EMPTY;
            else begin
              pos_nxt = first_un; raddr = AW'(first_un);
              sun_nxt[found_slot] = my_un - 1'b1;
              state_nxt = S_FETCH_CHK;
            end
          end
          REQ_REMOVE: begin
            pos_nxt = '0; raddr = '0;
            if (len_r == '0) st_nxt = ST_NOT_FOUND;
            else state_nxt = S_SRCH_CMP;
          end
          REQ_SET_CAP: begin
            if (ncap < len_r) begin
              // keep the newest ncap entries, copied down to the front
              pos_nxt = '0; rd_nxt = len_r - ncap;
              for (int k = 0; k < MAX_SUBSCRIBERS; k++)
                if (sv_r[k] && sun_r[k] > ncap) sun_nxt[k] = ncap;
              if (ncap == '0) len_nxt = '0;
              else state_nxt = S_WALK_RD;
            end
            cap_nxt = ncap;
          end
          default: ;
        endcase
      end
      // Read data of the first unread entry is here: take it, drop a reader.
      S_FETCH_CHK: begin
        msg_nxt = 32'(rword);
        state_nxt = S_DONE;
        if (rcnt <= CW'(1)) begin
          rd_nxt = pos_inc;
          if (pos_inc < len_r) state_nxt = S_WALK_RD;
          else len_nxt = len_r - 1'b1;
        end else begin
          we = 1'b1; wcnt = rcnt - 1'b1;
        end
      end
      // One compare per cycle; the next read is issued alongside.
      S_SRCH_CMP: begin
        if (rword == req_word) begin
          for (int k = 0; k < MAX_SUBSCRIBERS; k++)
            if (sv_r[k] && sun_r[k] != '0 &&
                (sun_r[k] > len_r || len_r - sun_r[k] <= pos_r))
              sun_nxt[k] = sun_r[k] - 1'b1;
          rd_nxt = pos_inc; state_nxt = S_DONE;
          if (pos_inc < len_r) state_nxt = S_WALK_RD;
          else len_nxt = len_r - 1'b1;
        end else if (pos_inc >= len_r) begin
          st_nxt = ST_NOT_FOUND; state_nxt = S_DONE;
        end else begin
          pos_nxt = pos_inc; raddr = AW'(pos_inc);
        end
      end
      // Copy entry rd to pos, read then write, until rd reaches the length.
      S_WALK_RD: begin
        raddr = AW'(rd_r); state_nxt = S_WALK_WR;
      end
      S_WALK_WR: begin
        if (keep) begin
          we = 1'b1; wcnt = filt_r ? rcnt - 1'b1 : rcnt;
          pos_nxt = pos_inc;
        end
        rd_nxt = rd_inc;
        if (rd_inc >= len_r) begin
          len_nxt = keep ? pos_inc : pos_r;
          state_nxt = S_DONE;
        end else state_nxt = S_WALK_RD;
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        out_nxt.status = st_r;
        out_nxt.message_out = msg_r;
        out_nxt.unread_count = hit_r ? 5'(sun_r[slot_r]) : 5'd0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; len_r <= '0; cap_r <= LW'(CAPACITY);
      sv_r <= '0; tot_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; len_r <= len_nxt; cap_r <= cap_nxt;
      sv_r <= sv_nxt; tot_r <= tot_nxt; ov_r <= ov_nxt;
    end
    if (start && !busy) req_r <= in_data;
    pos_r <= pos_nxt; rd_r <= rd_nxt; filt_r <= filt_nxt;
    slot_r <= slot_nxt; hit_r <= hit_nxt;
    st_r <= st_nxt; msg_r <= msg_nxt; out_r <= out_nxt;
    for (int k = 0; k < MAX_SUBSCRIBERS; k++) sun_r[k] <= sun_nxt[k];
    if (sid_we) sid_r[sid_wa] <= sid_wr;
  end

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(CAPACITY)) else $error("length over capacity");
  a_tot: assert property (@(posedge clk) disable iff (!rst_n)
    tot_r == TW'($countones(sv_r))) else $error("subscriber total mismatch");
endmodule
